[hw/rtl/btlv_pkg.sv]
package btlv_pkg;

    localparam int MAX_TAG_BYTES_DEF = 4;
    localparam int TAG_CNT_W         = 3;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] LEN_ONE_BYTE  = 8'h81;
    localparam logic [7:0] LEN_TWO_BYTES = 8'h82;
    localparam logic [4:0] TAG_MORE_MASK = 5'h1F;

    typedef enum logic [2:0] {
        PH_TAG_FIRST,
        PH_TAG_MORE,
        PH_LEN_FIRST,
        PH_LEN_EXT,
        PH_VALUE,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TAG_LONG = 2'd1,
        ERR_TRUNC    = 2'd2,
        ERR_LEN_FORM = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [31:0] tag_value;
        logic [15:0] value_length;
        logic [7:0]  value_byte;
        logic        carries_byte;
        logic        item_done;
        err_code_t   error_code;
    } result_t;

endpackage

[hw/rtl/btlv_front.sv]
module btlv_front #(
    parameter int MAX_TAG_BYTES = btlv_pkg::MAX_TAG_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             strict_length,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             end_of_stream,
    input  logic             push_ready,
    output logic             push_valid,
    output btlv_pkg::result_t push_data
);
    import btlv_pkg::*;

    phase_t                 phase_reg, phase_next, ph_mid;
    logic [31:0]            tag_reg, tag_next, tag_mid;
    logic [TAG_CNT_W-1:0]   cnt_reg, cnt_next, cnt_mid;
    logic [15:0]            len_reg, len_next, len_mid;
    logic [1:0]             lleft_reg, lleft_next, lleft_mid;
    logic [15:0]            vleft_reg, vleft_next, vleft_mid;

    err_code_t              err;
    logic                   have;
    logic                   done;
    logic [7:0]             vbyte;
    logic                   carries;
    logic                   accept;

    assign in_ready = push_ready;
    assign accept   = in_valid & push_ready;

    // per-byte decode of the current phase
    always_comb
    begin
        err       = ERR_NONE;
        have      = 1'b0;
        done      = 1'b0;
        vbyte     = 8'd0;
        carries   = 1'b0;
        ph_mid    = phase_reg;
        tag_mid   = tag_reg;
        cnt_mid   = cnt_reg;
        len_mid   = len_reg;
        lleft_mid = lleft_reg;
        vleft_mid = vleft_reg;
        case (phase_reg)
            PH_TAG_FIRST:
            begin
                tag_mid   = {24'd0, data_byte};
                cnt_mid   = TAG_CNT_W'(1);
                len_mid   = 16'd0;
                lleft_mid = 2'd0;
                vleft_mid = 16'd0;
                ph_mid    = (data_byte[4:0] == TAG_MORE_MASK) ? PH_TAG_MORE : PH_LEN_FIRST;
            end
            PH_TAG_MORE:
            begin
                if (cnt_reg >= TAG_CNT_W'(MAX_TAG_BYTES))
                begin
                    err = ERR_TAG_LONG;
                end
                else
                begin
                    tag_mid = {tag_reg[23:0], data_byte};
                    cnt_mid = cnt_reg + TAG_CNT_W'(1);
                    if (!data_byte[7])
                    begin
                        ph_mid = PH_LEN_FIRST;
                    end
                end
            end
            PH_LEN_FIRST:
            begin
                if (data_byte == LEN_ONE_BYTE)
                begin
                    lleft_mid = 2'd1;
                    len_mid   = 16'd0;
                    ph_mid    = PH_LEN_EXT;
                end
                else if (data_byte == LEN_TWO_BYTES)
                begin
                    lleft_mid = 2'd2;
                    len_mid   = 16'd0;
                    ph_mid    = PH_LEN_EXT;
                end
                else if (strict_length && data_byte[7])
                begin
                    err = ERR_LEN_FORM;
                end
                else
                begin
                    len_mid   = {8'd0, data_byte};
                    lleft_mid = 2'd0;
                    ph_mid    = PH_VALUE;
                end
            end
            PH_LEN_EXT:
            begin
                len_mid   = {len_reg[7:0], data_byte};
                lleft_mid = lleft_reg - 2'd1;
                if (lleft_reg == 2'd1)
                begin
                    ph_mid = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                have      = 1'b1;
                vbyte     = data_byte;
                carries   = 1'b1;
                vleft_mid = vleft_reg - 16'd1;
                if (vleft_reg == 16'd1)
                begin
                    done   = 1'b1;
                    ph_mid = PH_TAG_FIRST;
                end
            end
            default:
            begin
            end
        endcase

        // length just completed: load the value count, empty value ends here
        if (err == ERR_NONE && ph_mid == PH_VALUE && !have)
        begin
            vleft_mid = len_mid;
            if (len_mid == 16'd0)
            begin
                have   = 1'b1;
                done   = 1'b1;
                ph_mid = PH_TAG_FIRST;
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next = ph_mid;
        tag_next   = tag_mid;
        cnt_next   = cnt_mid;
        len_next   = len_mid;
        lleft_next = lleft_mid;
        vleft_next = vleft_mid;
        if (phase_reg == PH_SKIP)
        begin
            phase_next = end_of_stream ? PH_TAG_FIRST : PH_SKIP;
        end
        else if (err != ERR_NONE && !end_of_stream)
        begin
            phase_next = PH_SKIP;
        end
        if ((phase_reg == PH_SKIP || err != ERR_NONE || ph_mid == PH_TAG_FIRST) &&
            (end_of_stream || phase_reg != PH_SKIP) &&
            (end_of_stream || err == ERR_NONE))
        begin
            phase_next = PH_TAG_FIRST;
            tag_next   = 32'd0;
            cnt_next   = '0;
            len_next   = 16'd0;
            lleft_next = 2'd0;
            vleft_next = 16'd0;
        end
        else if (end_of_stream)
        begin
            phase_next = PH_TAG_FIRST;
            tag_next   = 32'd0;
            cnt_next   = '0;
            len_next   = 16'd0;
            lleft_next = 2'd0;
            vleft_next = 16'd0;
        end
    end

    // result
    always_comb
    begin
        push_valid             = 1'b0;
        push_data.tag_value    = tag_mid;
        push_data.value_length = len_mid;
        push_data.value_byte   = 8'd0;
        push_data.carries_byte = 1'b0;
        push_data.item_done    = 1'b1;
        push_data.error_code   = ERR_NONE;
        if (phase_reg != PH_SKIP)
        begin
            if (err != ERR_NONE)
            begin
                push_valid           = accept;
                push_data.error_code = err;
            end
            else if (end_of_stream && ph_mid != PH_TAG_FIRST)
            begin
                push_valid           = accept;
                push_data.error_code = ERR_TRUNC;
            end
            else if (have)
            begin
                push_valid             = accept;
                push_data.value_byte   = vbyte;
                push_data.carries_byte = carries;
                push_data.item_done    = done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG_FIRST;
            tag_reg   <= 32'd0;
            cnt_reg   <= '0;
            len_reg   <= 16'd0;
            lleft_reg <= 2'd0;
            vleft_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            lleft_reg <= lleft_next;
            vleft_reg <= vleft_next;
        end
    end

endmodule

[hw/rtl/btlv_queue.sv]
module btlv_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  btlv_pkg::result_t push_data,
    output logic              pop_valid,
    input  logic              pop,
    output btlv_pkg::result_t pop_data
);
    import btlv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/btlv_back.sv]
module btlv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  btlv_pkg::result_t q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output btlv_pkg::result_t out_data
);
    import btlv_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // refill the output beat whenever it is empty or being taken
    assign q_pop     = q_valid & (~valid_reg | out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_data;
        end
    end

endmodule

[hw/rtl/ber_tlv_stream_parser.sv]
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata = data_byte, tlast = end_of_stream
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata = tag, length, byte; tlast = item_done;
//                                             tuser = carries_byte, error_code
// apb       in   psel/penable, pready = 1     reg 0 at 0x0: strict_length
//
// One input beat per cycle while the result queue is not full; each beat is parsed in the cycle it is taken.
// A result passes through the result queue and then the output register before it leaves.
// Reset clears the parser state, the 4-deep result queue and strict_length.
// s_axis_tready drops only when the result queue is full; the queue plus the
// output register let input keep flowing while m_axis stalls briefly.
module ber_tlv_stream_parser #(
    parameter int MAX_TAG_BYTES = btlv_pkg::MAX_TAG_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] tag_value, [47:32] value_length,
                                        // [55:48] value_byte
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser,   // [0] carries_byte, [2:1] error_code
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import btlv_pkg::*;

    logic    strict_reg, strict_next;
    logic    cfg_sel;
    logic    push_valid, push_ready;
    result_t push_data;
    logic    q_valid, q_pop;
    result_t q_data;
    result_t out_data;

    assign pready  = 1'b1;
    assign cfg_sel = ~paddr[2];
    assign prdata  = cfg_sel ? {31'd0, strict_reg} : 32'd0;

    always_comb
    begin
        strict_next = strict_reg;
        if (psel && penable && pwrite && pready && cfg_sel)
        begin
            strict_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b0;
        end
        else
        begin
            strict_reg <= strict_next;
        end
    end

    btlv_front #(
        .MAX_TAG_BYTES (MAX_TAG_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .strict_length (strict_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .data_byte     (s_axis_tdata),
        .end_of_stream (s_axis_tlast),
        .push_ready    (push_ready),
        .push_valid    (push_valid),
        .push_data     (push_data)
    );

    btlv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    btlv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {out_data.value_byte, out_data.value_length, out_data.tag_value};
    assign m_axis_tlast = out_data.item_done;
    assign m_axis_tuser = {out_data.error_code, out_data.carries_byte};

endmodule

[tb/tb.sv]
module tb;
    import btlv_pkg::*;

    localparam int          CYCLE_LIMIT        = 400000;
    localparam int          DRAIN_CYCLES       = 8;
    localparam int          RANDOM_BEATS       = 1100;
    localparam int          MAX_TAG            = MAX_TAG_BYTES_DEF;
    localparam logic [2:0]  STRICT_LENGTH_ADDR = 3'h0;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        eos;
        result_t     want;
    } row_t;

    localparam result_t NO_RES = '0;

    // directed stream: empty value, multi-byte tag with 0x81 length, tag overflow,
    // truncation at length 0xFFFF, 0x82 length ending on eos, strict bad length
    localparam row_t DIR_ROWS [0:28] = '{
        '{ROW_PREDICT, 8'h5A, 1'b0, NO_RES},
        '{ROW_TYPED,   8'h00, 1'b0, '{32'h0000005A, 16'h0000, 8'h00, 1'b0, 1'b1, ERR_NONE}},
        '{ROW_PREDICT, 8'h1F, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h81, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h7F, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h81, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h01, 1'b0, NO_RES},
        '{ROW_TYPED,   8'hFF, 1'b0, '{32'h001F817F, 16'h0001, 8'hFF, 1'b1, 1'b1, ERR_NONE}},
        '{ROW_PREDICT, 8'hFF, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'hFF, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'hFF, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'hFF, 1'b0, NO_RES},
        '{ROW_TYPED,   8'h00, 1'b0, '{32'hFFFFFFFF, 16'h0000, 8'h00, 1'b0, 1'b1, ERR_TAG_LONG}},
        '{ROW_PREDICT, 8'hAA, 1'b1, NO_RES},
        '{ROW_PREDICT, 8'h02, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h82, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'hFF, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'hFF, 1'b0, NO_RES},
        '{ROW_TYPED,   8'h00, 1'b1, '{32'h00000002, 16'hFFFF, 8'h00, 1'b0, 1'b1, ERR_TRUNC}},
        '{ROW_PREDICT, 8'h04, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h82, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h00, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h02, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'hAB, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'hCD, 1'b1, NO_RES},
        '{ROW_CONFIG,  8'h01, 1'b0, NO_RES},
        '{ROW_PREDICT, 8'h05, 1'b0, NO_RES},
        '{ROW_TYPED,   8'h80, 1'b0, '{32'h00000005, 16'h0000, 8'h00, 1'b0, 1'b1, ERR_LEN_FORM}},
        '{ROW_PREDICT, 8'h11, 1'b1, NO_RES}
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // [31:0] tag_value, [47:32] value_length,
                                        // [55:48] value_byte
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;          // [0] carries_byte, [2:1] error_code
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // parser shadow state
    phase_t      pr_phase;
    logic [31:0] pr_tag;
    int unsigned pr_tag_cnt;
    logic [15:0] pr_len;
    logic [1:0]  pr_len_left;
    logic [15:0] pr_val_left;
    logic        pr_strict;

    result_t     pending_tlv_results [$];
    logic [8:0]  stream_q [$];          // [8] eos, [7:0] byte

    int unsigned cycle_count    = 0;
    int unsigned fail_count     = 0;
    int unsigned parsed_beats   = 0;
    int unsigned results_seen   = 0;
    int unsigned burst_left     = 0;
    int unsigned err_seen [4]   = '{0, 0, 0, 0};

    ber_tlv_stream_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_tlv_results.size());
        $display("FAIL");
        $finish;
    end

    function automatic void clear_item();
        pr_phase    = PH_TAG_FIRST;
        pr_tag      = '0;
        pr_tag_cnt  = 0;
        pr_len      = '0;
        pr_len_left = '0;
        pr_val_left = '0;
    endfunction

    function automatic void ref_reset_state();
        clear_item();
        pr_strict = 1'b0;
    endfunction

    function automatic void expect_result(input result_t r);
        pending_tlv_results.insert(pending_tlv_results.size(), r);
    endfunction

    // Advances the shadow parser by one byte; queues the result it yields.
    task automatic decode_tlv_byte(input logic [7:0] b, input logic eos, output int n);
        err_code_t  err;
        logic       have;
        logic [7:0] vb;
        logic       carries;
        logic       done;
        err     = ERR_NONE;
        have    = 1'b0;
        vb      = '0;
        carries = 1'b0;
        done    = 1'b0;
        n       = 0;
        if (pr_phase == PH_SKIP)
        begin
            if (eos)
                clear_item();
        end
        else
        begin
            parsed_beats++;
            case (pr_phase)
                PH_TAG_MORE:
                begin
                    if (pr_tag_cnt >= MAX_TAG)
                        err = ERR_TAG_LONG;
                    else
                    begin
                        pr_tag = {pr_tag[23:0], b};
                        pr_tag_cnt++;
                        if (!b[7])
                            pr_phase = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST:
                begin
                    if (b == LEN_ONE_BYTE || b == LEN_TWO_BYTES)
                    begin
                        pr_len_left = (b == LEN_ONE_BYTE) ? 2'd1 : 2'd2;
                        pr_len      = '0;
                        pr_phase    = PH_LEN_EXT;
                    end
                    else if (pr_strict && b[7])
                        err = ERR_LEN_FORM;
                    else
                    begin
                        pr_len      = {8'h00, b};
                        pr_len_left = '0;
                        pr_phase    = PH_VALUE;
                    end
                end
                PH_LEN_EXT:
                begin
                    pr_len      = {pr_len[7:0], b};
                    pr_len_left = pr_len_left - 2'd1;
                    if (pr_len_left == 0)
                        pr_phase = PH_VALUE;
                end
                PH_VALUE:
                begin
                    have        = 1'b1;
                    vb          = b;
                    carries     = 1'b1;
                    pr_val_left = pr_val_left - 16'd1;
                    if (pr_val_left == 0)
                    begin
                        done     = 1'b1;
                        pr_phase = PH_TAG_FIRST;
                    end
                end
                default:
                begin
                    clear_item();
                    pr_tag     = {24'h0, b};
                    pr_tag_cnt = 1;
                    pr_phase   = (b[4:0] == TAG_MORE_MASK) ? PH_TAG_MORE : PH_LEN_FIRST;
                end
            endcase

            // length just completed: an empty value finishes the item at once
            if (err == ERR_NONE && pr_phase == PH_VALUE && !have)
            begin
                pr_val_left = pr_len;
                if (pr_val_left == 0)
                begin
                    have     = 1'b1;
                    done     = 1'b1;
                    pr_phase = PH_TAG_FIRST;
                end
            end

            if (err != ERR_NONE)
            begin
                expect_result('{pr_tag, pr_len, 8'h00, 1'b0, 1'b1, err});
                n = 1;
                if (eos)
                    clear_item();
                else
                    pr_phase = PH_SKIP;
            end
            else if (eos)
            begin
                if (pr_phase != PH_TAG_FIRST)
                begin
                    expect_result('{pr_tag, pr_len, 8'h00, 1'b0, 1'b1, ERR_TRUNC});
                    n = 1;
                end
                else if (have)
                begin
                    expect_result('{pr_tag, pr_len, vb, carries, done, ERR_NONE});
                    n = 1;
                end
                clear_item();
            end
            else if (have)
            begin
                expect_result('{pr_tag, pr_len, vb, carries, done, ERR_NONE});
                n = 1;
                if (pr_phase == PH_TAG_FIRST)
                    clear_item();
            end
        end
    endtask

    // Sender: bursts of random length, random gaps in between.
    task automatic send_byte(input logic [7:0] b, input logic eos, output int n);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        decode_tlv_byte(b, eos, n);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_tlv_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_strict(input logic val);
        logic [31:0] rd;
        wait_idle();
        apb_access(1'b1, STRICT_LENGTH_ADDR, {31'h0, val}, rd);
        pr_strict = val;
        apb_access(1'b0, STRICT_LENGTH_ADDR, '0, rd);
        if (rd[0] !== val)
        begin
            $error("strict_length readback: expected %0d, got %0d", val, rd[0]);
            fail_count++;
        end
    endtask

    function automatic void push_stream_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), {1'b0, b});
    endfunction

    task automatic append_tlv(input logic strict);
        int unsigned ntag;
        int unsigned form;
        int unsigned len;
        logic [7:0]  b;
        ntag = ($urandom_range(0, 19) == 0) ? MAX_TAG + 1 : $urandom_range(1, MAX_TAG);
        for (int i = 0; i < ntag; i++)
        begin
            b = 8'($urandom);
            if (i == 0)
            begin
                if (ntag == 1)
                begin
                    if (b[4:0] == TAG_MORE_MASK)
                        b[0] = 1'b0;
                end
                else
                    b[4:0] = TAG_MORE_MASK;
            end
            else
                b[7] = (i < ntag - 1);
            push_stream_byte(b);
        end

        form = $urandom_range(0, 29);
        if (strict && form < 2)
        begin
            b = ($urandom_range(0, 3) == 0) ? 8'h80 : 8'($urandom_range(8'h83, 8'hFF));
            push_stream_byte(b);
            len = $urandom_range(0, 3);
        end
        else if (form < 14)
        begin
            len = $urandom_range(0, 12);
            push_stream_byte(8'(len));
        end
        else if (form < 20)
        begin
            len = $urandom_range(0, 40);
            push_stream_byte(LEN_ONE_BYTE);
            push_stream_byte(8'(len));
        end
        else if (form == 26)
        begin
            // long value; literal length byte only when the mode allows it
            len = $urandom_range(128, 255);
            if (strict)
                push_stream_byte(LEN_ONE_BYTE);
            push_stream_byte(8'(len));
        end
        else
        begin
            len = (form < 26) ? $urandom_range(0, 20) : $urandom_range(0, 6);
            push_stream_byte(LEN_TWO_BYTES);
            push_stream_byte(8'(len >> 8));
            push_stream_byte(8'(len));
        end
        repeat (len) push_stream_byte(8'($urandom));
    endtask

    task automatic build_stream(input logic strict);
        int unsigned shape;
        int unsigned cut;
        stream_q.delete();
        repeat ($urandom_range(1, 5)) append_tlv(strict);
        shape = $urandom_range(0, 9);
        if (shape == 0 && stream_q.size() > 1)
        begin
            cut = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > cut)
                void'(stream_q.pop_back());
        end
        else if (shape == 1)
            repeat ($urandom_range(1, 8)) push_stream_byte(8'($urandom));
        stream_q[stream_q.size() - 1][8] = 1'b1;
    endtask

    // Receiver: stall pattern switches between modes, each held for a random span
    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (tick % 5) != 0;
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_tlv_results.size() == 0)
            begin
                $error("result beat with nothing expected: tdata 0x%0h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_tlv_results.pop_front();
                results_seen++;
                err_seen[want.error_code]++;
                check_field("tag_value",    want.tag_value,    m_axis_tdata[31:0]);
                check_field("value_length", want.value_length, m_axis_tdata[47:32]);
                check_field("value_byte",   want.value_byte,   m_axis_tdata[55:48]);
                check_field("carries_byte", want.carries_byte, m_axis_tuser[0]);
                check_field("item_done",    want.item_done,    m_axis_tlast);
                check_field("error_code",   want.error_code,   m_axis_tuser[2:1]);
            end
        end
    end

    initial
    begin
        int          n;
        int unsigned target;
        ref_reset_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_CONFIG)
                set_strict(DIR_ROWS[i].data[0]);
            else
            begin
                send_byte(DIR_ROWS[i].data, DIR_ROWS[i].eos, n);
                if (DIR_ROWS[i].kind == ROW_TYPED)
                begin
                    if (n != 0)
                        pending_tlv_results[pending_tlv_results.size() - 1] =
                            DIR_ROWS[i].want;
                    else
                        expect_result(DIR_ROWS[i].want);
                end
            end
        end

        // alternate length modes, both values written
        for (int ph = 0; ph < 4; ph++)
        begin
            set_strict(ph[0]);
            target = parsed_beats + RANDOM_BEATS / 4;
            while (parsed_beats < target)
            begin
                build_stream(ph[0]);
                foreach (stream_q[k])
                    send_byte(stream_q[k][7:0], stream_q[k][8], n);
            end
        end

        wait_idle();
        $display("Parsed %0d stream beats in lenient and strict length modes, %0d results checked",
                 parsed_beats, results_seen);
        $display("Error results: tag too long %0d, truncated %0d, bad length form %0d",
                 err_seen[ERR_TAG_LONG], err_seen[ERR_TRUNC], err_seen[ERR_LEN_FORM]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/btlv_pkg.sv
hw/rtl/btlv_front.sv
hw/rtl/btlv_queue.sv
hw/rtl/btlv_back.sv
hw/rtl/ber_tlv_stream_parser.sv
tb/tb.sv
